FILE: design/rcsf_pkg.sv
// Shared types and constants for the RGB cross sharpen filter.
package rcsf_pkg;

   // Parameter defaults
   localparam int DEFAULT_MAX_WIDTH    = 1024;
   localparam int DEFAULT_CHANNEL_BITS = 8;

   // Configuration register widths and reset values
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 13;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 13;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // Which neighbours of the centre pixel lie inside the image
   typedef struct packed {
      logic has_up;
      logic has_down;
      logic has_left;
      logic has_right;
   } edge_flags_type;

   // Per transaction control carried from the input stage to the result stage
   typedef struct packed {
      logic           emit;
      logic           eor;
      logic           eof;
      edge_flags_type edges;
   } slot_ctrl_type;

endpackage

FILE: design/rgb_cross_sharpen_filter.sv
// Top level of the RGB cross sharpen filter: stream control, window and result register.
//
//  Channel  Direction  Handshake               Payload
//  req_     in         req_tvalid/req_tready   tdata {blue,green,red}, tuser is_padding
//  rsp_     out        rsp_tvalid/rsp_tready   tdata {blue,green,red}, tlast end_of_row,
//                                              tuser end_of_frame
//  csr_     in         csr_valid/csr_ready     csr_index, csr_data
//
// One pixel transaction per clock. A transaction is taken into the input register together
// with its line store read, and the result it completes passes to the output register as the
// input stage retires; the result for a pixel is formed by the transaction one row plus
// one pixel behind it. Reset restores the default image size and clears counters and the
// window; the line store needs no clearing. The input stage stalls only while it holds a
// result and the output register is full and not being taken.
module rgb_cross_sharpen_filter #(
   parameter int MAX_WIDTH    = rcsf_pkg::DEFAULT_MAX_WIDTH,
   parameter int CHANNEL_BITS = rcsf_pkg::DEFAULT_CHANNEL_BITS
) (
   input  logic clock,
   input  logic reset,
   // Pixel input
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]    req_tdata,  // red, green, blue, zero fill
   input  logic                                   req_tuser,  // is_padding
   // Filtered output
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]    rsp_tdata,  // red, green, blue, zero fill
   output logic                                   rsp_tlast,  // end_of_row
   output logic                                   rsp_tuser,  // end_of_frame
   // Register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rcsf_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rcsf_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int PIX_W   = 3 * CHANNEL_BITS;
   localparam int TDATA_W = ((PIX_W + 7) / 8) * 8;
   localparam int WORD_W  = 2 * PIX_W;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int CMP_W   = ((COL_W > rcsf_pkg::WIDTH_BITS) ? COL_W : rcsf_pkg::WIDTH_BITS) + 1;
   localparam int HGT_W   = rcsf_pkg::HEIGHT_BITS;
   localparam int ROW_W   = HGT_W + 1;

   // Configuration
   logic [rcsf_pkg::WIDTH_BITS-1:0] width_ff, width_in;
   logic [HGT_W-1:0]                height_ff, height_in;
   logic                            csr_write;

   // Stream counters
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [HGT_W-1:0] out_row_ff, out_row_in;

   // Input stage
   logic                    s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]        s1_px_ff;
   logic [COL_W-1:0]        s1_addr_ff;
   rcsf_pkg::slot_ctrl_type s1_ctrl_ff, slot_ctrl;
   logic                    s1_move;

   // Window and held vertical neighbours
   logic [PIX_W-1:0] win0_ff, win1_ff, above_ff, below_ff;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_eor_ff, rsp_eof_ff;

   // Decode
   logic [CMP_W-1:0] eff_w_x, raw_w_x, ic_x, oc_x;
   logic [HGT_W-1:0] eff_h;
   logic [ROW_W-1:0] eff_h_x;
   logic             accept, take, in_frame, col_last, restart;
   logic [PIX_W-1:0] px;

   // Line store
   logic [WORD_W-1:0] rd_data;
   logic [PIX_W-1:0]  mid_old, up_old, filtered;

   // Effective image size
   assign raw_w_x = CMP_W'(width_ff);
   always_comb begin
      if (width_ff == '0) begin
         eff_w_x = CMP_W'(1);
      end else if (raw_w_x > CMP_W'(MAX_WIDTH)) begin
         eff_w_x = CMP_W'(MAX_WIDTH);
      end else begin
         eff_w_x = raw_w_x;
      end
   end
   assign eff_h   = (height_ff == '0) ? HGT_W'(1) : height_ff;
   assign eff_h_x = ROW_W'(eff_h);

   // Input transaction decode
   assign accept   = req_tvalid && req_tready;
   assign in_frame = in_row_ff < eff_h_x;
   assign take     = accept && !(req_tuser && in_frame);
   assign px       = in_frame ? req_tdata[PIX_W-1:0] : '0;
   assign ic_x     = CMP_W'(in_col_ff);
   assign oc_x     = CMP_W'(out_col_ff);
   assign col_last = (ic_x + CMP_W'(1)) >= eff_w_x;

   // Position of the result this transaction completes
   always_comb begin
      slot_ctrl.emit = !((in_row_ff == '0) || ((in_row_ff == ROW_W'(1)) && (in_col_ff == '0)));
      slot_ctrl.eor  = (oc_x + CMP_W'(1)) >= eff_w_x;
      slot_ctrl.edges.has_up    = out_row_ff != '0;
      slot_ctrl.edges.has_left  = out_col_ff != '0;
      slot_ctrl.edges.has_right = !slot_ctrl.eor;
      slot_ctrl.edges.has_down  = (ROW_W'(out_row_ff) + ROW_W'(1)) < eff_h_x;
      slot_ctrl.eof  = slot_ctrl.eor && !slot_ctrl.edges.has_down;
   end
   assign restart = slot_ctrl.emit && slot_ctrl.eof;

   // Register writes
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (csr_index)
            rcsf_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_data[rcsf_pkg::WIDTH_BITS-1:0];
            rcsf_pkg::CSR_IMAGE_HEIGHT: height_in = csr_data[HGT_W-1:0];
            default: ;
         endcase
      end
   end

   // Counter update: a register write or the frame's last result restarts the frame
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_write || (take && restart)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (col_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (slot_ctrl.emit) begin
            if (slot_ctrl.eor) begin
               out_col_in = '0;
               out_row_in = out_row_ff + HGT_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   // Stage handshake
   assign s1_move    = s1_valid_ff && (!s1_ctrl_ff.emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign s1_valid_in = take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_move && s1_ctrl_ff.emit) ? 1'b1
                       : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Line store: upper row takes the old middle row, middle row takes the new pixel
   rcsf_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W),
      .DATA_W (WORD_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (take),
      .rd_addr (in_col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_move),
      .wr_addr (s1_addr_ff),
      .wr_data ({mid_old, s1_px_ff})
   );
   assign mid_old = rd_data[PIX_W-1:0];
   assign up_old  = rd_data[WORD_W-1:PIX_W];

   // Kernel on the window as it stands after this transaction's shift
   rcsf_kernel #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_kernel (
      .centre   (win0_ff),
      .up       (above_ff),
      .down     (below_ff),
      .left     (win1_ff),
      .right    (mid_old),
      .edges    (s1_ctrl_ff.edges),
      .filtered (filtered)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rcsf_pkg::WIDTH_RESET;
         height_ff    <= rcsf_pkg::HEIGHT_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win0_ff      <= '0;
         win1_ff      <= '0;
         above_ff     <= '0;
         below_ff     <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // Window shift as the input stage retires
         if (s1_move) begin
            win0_ff  <= mid_old;
            win1_ff  <= win0_ff;
            above_ff <= up_old;
            below_ff <= s1_px_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         s1_px_ff   <= px;
         s1_addr_ff <= in_col_ff;
         s1_ctrl_ff <= slot_ctrl;
      end
      if (s1_move && s1_ctrl_ff.emit) begin
         rsp_pixel_ff <= filtered;
         rsp_eor_ff   <= s1_ctrl_ff.eor;
         rsp_eof_ff   <= s1_ctrl_ff.eof;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_pixel_ff);
   assign rsp_tlast  = rsp_eor_ff;
   assign rsp_tuser  = rsp_eof_ff;

   // Checks
   a_in_col_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(in_col_ff) < eff_w_x)
      else $error("input column beyond image width");

   a_out_col_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(out_col_ff) < eff_w_x)
      else $error("output column beyond image width");

   a_eof_on_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eof_ff |-> rsp_eor_ff)
      else $error("end of frame without end of row");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ctrl_ff.emit && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while a pending result is blocked");

endmodule

FILE: design/rcsf_line_store.sv
// Two-row line store: one word per column holding the upper and middle row pixels.
module rcsf_line_store #(
   parameter int DEPTH  = rcsf_pkg::DEFAULT_MAX_WIDTH,
   parameter int ADDR_W = $clog2(rcsf_pkg::DEFAULT_MAX_WIDTH),
   parameter int DATA_W = 6 * rcsf_pkg::DEFAULT_CHANNEL_BITS
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a write to the same column in the same cycle is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rcsf_kernel.sv
// Cross kernel: 5 x centre minus the in-image neighbours, saturated per channel.
module rcsf_kernel #(
   parameter int CHANNEL_BITS = rcsf_pkg::DEFAULT_CHANNEL_BITS
) (
   input  logic [3*CHANNEL_BITS-1:0] centre,
   input  logic [3*CHANNEL_BITS-1:0] up,
   input  logic [3*CHANNEL_BITS-1:0] down,
   input  logic [3*CHANNEL_BITS-1:0] left,
   input  logic [3*CHANNEL_BITS-1:0] right,
   input  rcsf_pkg::edge_flags_type  edges,
   output logic [3*CHANNEL_BITS-1:0] filtered
);

   // 5 x max fits in CHANNEL_BITS+3 bits, plus a sign bit
   localparam int SUM_W = CHANNEL_BITS + 4;
   localparam logic signed [SUM_W-1:0] CHAN_MAX = SUM_W'((1 << CHANNEL_BITS) - 1);

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic signed [SUM_W-1:0] c_s, u_s, d_s, l_s, r_s, sum;

      assign c_s = $signed(SUM_W'(centre[ch*CHANNEL_BITS +: CHANNEL_BITS]));
      assign u_s = edges.has_up    ? $signed(SUM_W'(up[ch*CHANNEL_BITS +: CHANNEL_BITS]))
                                   : '0;
      assign d_s = edges.has_down  ? $signed(SUM_W'(down[ch*CHANNEL_BITS +: CHANNEL_BITS]))
                                   : '0;
      assign l_s = edges.has_left  ? $signed(SUM_W'(left[ch*CHANNEL_BITS +: CHANNEL_BITS]))
                                   : '0;
      assign r_s = edges.has_right ? $signed(SUM_W'(right[ch*CHANNEL_BITS +: CHANNEL_BITS]))
                                   : '0;

      // 5c as 4c + c
      assign sum = (c_s <<< 2) + c_s - u_s - d_s - l_s - r_s;

      // Clamp to 0..max
      always_comb begin
         if (sum < 0) begin
            filtered[ch*CHANNEL_BITS +: CHANNEL_BITS] = '0;
         end else if (sum > CHAN_MAX) begin
            filtered[ch*CHANNEL_BITS +: CHANNEL_BITS] = CHAN_MAX[CHANNEL_BITS-1:0];
         end else begin
            filtered[ch*CHANNEL_BITS +: CHANNEL_BITS] = sum[CHANNEL_BITS-1:0];
         end
      end
   end

endmodule

FILE: bench/tb.sv
// Self-checking bench for the RGB cross sharpen filter: stream driver, result monitor, predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W         = rcsf_pkg::DEFAULT_MAX_WIDTH;
   localparam int CHAN_BITS     = rcsf_pkg::DEFAULT_CHANNEL_BITS;
   localparam int CHAN_MAX      = (1 << CHAN_BITS) - 1;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 150;

   // One pixel, red in element 0 so it lines up with tdata
   typedef logic [2:0][CHAN_BITS-1:0] pixel_type;

   typedef struct {
      pixel_type px;
      bit        pad;
   } pixel_item_type;

   typedef struct packed {
      pixel_type px;
      logic      eor;
      logic      eof;
   } result_type;

   typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_SMOOTH} texture_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [3*CHAN_BITS-1:0]              req_tdata  = '0;    // red, green, blue
   logic                                req_tuser  = 1'b0;  // is_padding
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [3*CHAN_BITS-1:0]              rsp_tdata;          // red, green, blue
   logic                                rsp_tlast;          // end_of_row
   logic                                rsp_tuser;          // end_of_frame
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [rcsf_pkg::CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [rcsf_pkg::CSR_DATA_BITS-1:0]  csr_data   = '0;

   // Traffic queues and bench controls
   pixel_item_type pixels_to_send[$];
   result_type     sharpened_due[$];
   int             gap_pct       = 0;
   int             stall_pct     = 0;
   int             hold_requests = 0;
   int             hold_served   = 0;
   int             hold_left     = 0;
   int             mismatches    = 0;
   int             quiet_cycles  = 0;
   int             random_items  = 0;

   // Predictor state
   logic [rcsf_pkg::WIDTH_BITS-1:0]  cfg_width;
   logic [rcsf_pkg::HEIGHT_BITS-1:0] cfg_height;
   pixel_type   upper_line  [MAX_W];
   pixel_type   middle_line [MAX_W];
   pixel_type   win_right, win_centre, win_left;
   pixel_type   held_above, held_below;
   int unsigned in_col, in_row, out_col, out_row;

   rgb_cross_sharpen_filter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5ns clock = ~clock;

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic void restart_counters();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
   endfunction

   // Advance the filter by one accepted transaction; emit is set when a pixel completes
   function automatic void sharpen_pixel(input pixel_type px_in, input bit pad_in,
                                         output bit emit, output result_type res);
      int unsigned w, h, ic, pos, tr, tc;
      bit          pad;
      pixel_type   px, mid_old, up_old, above, below;
      bit          has_up, has_down, has_left, has_right;
      int          sum;
      emit = 1'b0;
      res  = '0;
      w    = eff_width();
      h    = eff_height();
      ic   = (in_col < w) ? in_col : 0;
      pos  = in_row * w + ic;
      pad  = pad_in;
      // padding within the frame is dropped; anything past the last pixel flushes
      if (pad && pos < w * h) return;
      if (pos >= w * h) pad = 1'b1;

      px      = pad ? '0 : px_in;
      mid_old = middle_line[ic];
      up_old  = upper_line[ic];
      upper_line[ic]  = mid_old;
      middle_line[ic] = px;
      win_left   = win_centre;
      win_centre = win_right;
      win_right  = mid_old;
      above      = held_above;
      held_above = up_old;
      below      = held_below;
      held_below = px;

      ic++;
      if (ic >= w) begin
         ic = 0;
         in_row++;
      end
      in_col = ic;
      if (pos < w + 1) return;

      // centre pixel is one row plus one pixel behind the input
      tr        = out_row;
      tc        = out_col;
      has_up    = tr > 0;
      has_left  = tc > 0;
      has_right = tc + 1 < w;
      has_down  = tr + 1 < h;
      for (int ch = 0; ch < 3; ch++) begin
         sum = 5 * int'(win_centre[ch]);
         if (has_up)    sum -= int'(above[ch]);
         if (has_left)  sum -= int'(win_left[ch]);
         if (has_right) sum -= int'(win_right[ch]);
         if (has_down)  sum -= int'(below[ch]);
         if (sum < 0) sum = 0;
         else if (sum > CHAN_MAX) sum = CHAN_MAX;
         res.px[ch] = sum[CHAN_BITS-1:0];
      end
      res.eor = (tc + 1 >= w);
      res.eof = res.eor && (tr + 1 >= h);
      emit    = 1'b1;

      if (res.eof) begin
         restart_counters();
      end else if (res.eor) begin
         out_col = 0;
         out_row = tr + 1;
      end else begin
         out_col = tc + 1;
      end
   endfunction

   function automatic pixel_type random_pixel(input texture_type style);
      pixel_type px;
      int        base;
      base = $urandom_range(CHAN_MAX);
      for (int ch = 0; ch < 3; ch++) begin
         case (style)
            TEXTURE_BINARY: px[ch] = $urandom_range(1) ? CHAN_MAX[CHAN_BITS-1:0] : '0;
            TEXTURE_SMOOTH: px[ch] = CHAN_BITS'(base) ^ CHAN_BITS'($urandom_range(7));
            default:        px[ch] = CHAN_BITS'($urandom_range(CHAN_MAX));
         endcase
      end
      return px;
   endfunction

   task automatic send_pixel(input pixel_type px, input bit pad);
      pixel_item_type item;
      item.px  = px;
      item.pad = pad;
      pixels_to_send.push_back(item);
   endtask

   // Wait for the stream to empty, then let the pipeline settle
   task automatic drain();
      while (pixels_to_send.size() != 0 || req_tvalid || sharpened_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [rcsf_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [rcsf_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == rcsf_pkg::CSR_IMAGE_WIDTH) cfg_width = data[rcsf_pkg::WIDTH_BITS-1:0];
      else cfg_height = data[rcsf_pkg::HEIGHT_BITS-1:0];
      restart_counters();
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Full frame of random content followed by enough flush items
   task automatic run_frame(input int w_reg, input int h_reg, input texture_type style,
                            input int pad_pct);
      int w, h;
      write_reg(rcsf_pkg::CSR_IMAGE_WIDTH, {2'($urandom_range(3)), 11'(w_reg)});
      write_reg(rcsf_pkg::CSR_IMAGE_HEIGHT, 13'(h_reg));
      w = eff_width();
      h = eff_height();
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(99) < pad_pct) send_pixel(random_pixel(TEXTURE_NOISE), 1'b1);
         send_pixel(random_pixel(style), 1'b0);
      end
      for (int i = 0; i <= w; i++)
         send_pixel(random_pixel(TEXTURE_NOISE), $urandom_range(3) != 0);
      random_items += w * h + w + 1;
      drain();
   endtask

   // Input driver: predicts on each transaction, then offers the next queued item
   always @(posedge clock) begin : drive_pixels
      pixel_item_type item;
      result_type     res;
      bit             emit;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sharpen_pixel(req_tdata, req_tuser, emit, res);
            if (emit) sharpened_due.push_back(res);
         end
         if (!req_tvalid || req_tready) begin
            if (pixels_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
               item = pixels_to_send.pop_front();
               req_tdata  <= item.px;
               req_tuser  <= item.pad;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure and the long hold-off
   always @(posedge clock) begin : check_pixels
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (sharpened_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result: rgb=%h eor=%b eof=%b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = sharpened_due.pop_front();
               if (rsp_tdata[CHAN_BITS-1:0] !== want.px[0] ||
                   rsp_tdata[2*CHAN_BITS-1:CHAN_BITS] !== want.px[1] ||
                   rsp_tdata[3*CHAN_BITS-1:2*CHAN_BITS] !== want.px[2] ||
                   rsp_tlast !== want.eor || rsp_tuser !== want.eof) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("mismatch: want rgb=%h/%h/%h eor=%b eof=%b got rgb=%h eor=%b eof=%b",
                              want.px[0], want.px[1], want.px[2], want.eor, want.eof,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      pixel_type px;
      int        gap_by_phase   [4] = '{0, 64, 0, 25};
      int        stall_by_phase [4] = '{0, 0, 64, 25};

      // predictor starts from the reset state
      cfg_width  = rcsf_pkg::WIDTH_RESET;
      cfg_height = rcsf_pkg::HEIGHT_RESET;
      foreach (upper_line[i]) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      win_right  = '0;
      win_centre = '0;
      win_left   = '0;
      held_above = '0;
      held_below = '0;
      restart_counters();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 3x3 checkerboard: saturation both ways, every border, padding mid-frame,
      // flush made of padding and of real pixels past the frame end
      write_reg(rcsf_pkg::CSR_IMAGE_WIDTH, 13'd3);
      write_reg(rcsf_pkg::CSR_IMAGE_HEIGHT, 13'd3);
      for (int i = 0; i < 9; i++) begin
         px[0] = (i % 2 == 0) ? CHAN_MAX[CHAN_BITS-1:0] : '0;
         px[1] = (i % 2 == 0) ? '0 : CHAN_MAX[CHAN_BITS-1:0];
         px[2] = CHAN_BITS'(i * 31);
         send_pixel(px, 1'b0);
         if (i == 4) send_pixel('1, 1'b1);
      end
      send_pixel('0, 1'b1);
      send_pixel('1, 1'b0);
      send_pixel(random_pixel(TEXTURE_NOISE), 1'b1);
      send_pixel(random_pixel(TEXTURE_NOISE), 1'b0);
      drain();

      // zero width (junk in the upper data bits) and zero height: a single pixel frame
      write_reg(rcsf_pkg::CSR_IMAGE_WIDTH, 13'h1800);
      write_reg(rcsf_pkg::CSR_IMAGE_HEIGHT, 13'd0);
      send_pixel('1, 1'b0);
      send_pixel('0, 1'b1);
      send_pixel('1, 1'b1);
      drain();

      // random frames under each idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         gap_pct   = gap_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         while (random_items < (phase + 1) * PHASE_ITEMS)
            run_frame(($urandom_range(9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 12),
                      $urandom_range(1, 6), texture_type'($urandom_range(2)),
                      $urandom_range(1) ? 8 : 0);
         // abandoned frame; the next register write restarts the stream
         if (phase == 1) begin
            write_reg(rcsf_pkg::CSR_IMAGE_WIDTH, 13'd5);
            write_reg(rcsf_pkg::CSR_IMAGE_HEIGHT, 13'd4);
            for (int i = 0; i < 13; i++) send_pixel(random_pixel(TEXTURE_NOISE), 1'b0);
            drain();
         end
      end

      // long receiver hold-off while the sender keeps offering
      gap_pct   = 0;
      stall_pct = 0;
      hold_requests++;
      run_frame(16, 8, TEXTURE_NOISE, 0);

      // widest line (clamped), cut short once the first results of the top row are out
      write_reg(rcsf_pkg::CSR_IMAGE_WIDTH, 13'd2047);
      write_reg(rcsf_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      for (int i = 0; i < 1060; i++) send_pixel(random_pixel(TEXTURE_NOISE), 1'b0);
      drain();

      // tallest frame, one pixel wide, cut short
      write_reg(rcsf_pkg::CSR_IMAGE_WIDTH, 13'd1);
      write_reg(rcsf_pkg::CSR_IMAGE_HEIGHT, 13'd8191);
      for (int i = 0; i < 200; i++)
         send_pixel(random_pixel(TEXTURE_SMOOTH), $urandom_range(24) == 0);
      drain();

      if (mismatches == 0 && sharpened_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
